/* rtl/spwm_pkg.sv */
// ----------------------------------------------------------------------------
// spwm_pkg
// Shared types and constants of the servo / slow PWM pin generator.
// ----------------------------------------------------------------------------
package spwm_pkg;

  localparam int CHAN_W  = 3;
  localparam int MODE_W  = 2;
  localparam int VALUE_W = 32;
  localparam int PINS    = 8;
  localparam int PWM_W   = 20;
  localparam int DUTY_W  = 12;

  localparam logic [DUTY_W-1:0]  DUTY_FULL       = 12'hfff;
  localparam int                 SERVO_WIDTH_RST = 1500;
  localparam logic [VALUE_W-1:0] READ_ALL_ONES   = 32'hffff_ffff;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_IN    = 2'd0,
    MODE_OUT   = 2'd1,
    MODE_SERVO = 2'd2,
    MODE_PWM   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [PWM_W-1:0] on_time;
    logic [PWM_W-1:0] period;
  } pwm_cfg_t;

  typedef struct packed {
    logic fire;
    logic level;
  } servo_evt_t;

  typedef struct packed {
    logic [PINS-1:0]    pin_in;
    logic [VALUE_W-1:0] value;
    logic [MODE_W-1:0]  mode;
    logic [CHAN_W-1:0]  channel;
    logic [1:0]         op;
  } item_t;

endpackage

/* rtl/servo_pwm_pin_generator_top.sv */
// ----------------------------------------------------------------------------
// servo_pwm_pin_generator_top
// Eight-pin generator: multiplexed servo pulses, slow PWM, pin read/write.
// ----------------------------------------------------------------------------
// Path: input word into the input register, result word into the result register.
// Throughput: one word per cycle unless the result side stalls, set by the
//   single-pass update of the channel registers between the input and the result register.
// Reset: rst synchronous, active high; empties both registers and returns
//   every channel to input mode, servo width 1500, PWM stopped.
module servo_pwm_pin_generator_top #(
  parameter int NUM_CHANNELS   = 8,
  parameter int SLOT_US        = 4000,
  parameter int PWM_MIN_PERIOD = 1000
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // channel[2:0], mode[4:3], value[36:5], pin_in[44:37]
  input  logic [1:0]  s_tuser,  // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata   // pin_level[7:0], pin_drive[15:8], read_mode[17:16],
                                // read_value[49:18]
);

  localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int SW_W  = $clog2(((SLOT_US > spwm_pkg::SERVO_WIDTH_RST) ?
                                 SLOT_US : spwm_pkg::SERVO_WIDTH_RST) + 1);
  localparam int IDX_W = (CH_W > spwm_pkg::CHAN_W) ? CH_W : spwm_pkg::CHAN_W;
  localparam int PW    = spwm_pkg::PWM_W;
  localparam int DW    = spwm_pkg::DUTY_W;
  localparam int NP    = spwm_pkg::PINS;
  localparam int VW    = spwm_pkg::VALUE_W;

  spwm_pkg::item_t in_r;
  logic            in_vld;
  logic            out_rdy, proc;

  logic [NP-1:0]            pin_level, pin_drive;
  logic [spwm_pkg::MODE_W-1:0] read_mode;
  logic [VW-1:0]            read_value;
  logic [NP-1:0]            lvl_out, drv_out;
  spwm_pkg::mode_t          rd_mode;
  logic [VW-1:0]            rd_value;

  spwm_pkg::op_t   op;
  logic [IDX_W-1:0] ch_ext;
  logic [CH_W-1:0] idx;
  logic            ch_ok, tick, wr;

  logic [PW-1:0]    per, per_min;
  logic [DW-1:0]    duty;
  logic [PW+DW-1:0] prod;
  spwm_pkg::pwm_cfg_t wr_pwm;
  logic [SW_W-1:0]  wr_width;

  logic [CH_W-1:0]      seq_chan;
  spwm_pkg::servo_evt_t seq_evt;

  spwm_pkg::mode_t  mode_nx  [NUM_CHANNELS];
  logic [SW_W-1:0]  width_arr[NUM_CHANNELS];
  logic [NUM_CHANNELS-1:0] level_nx;

  // input and result registers
  assign out_rdy  = !m_tvalid || m_tready;
  assign proc     = in_vld && out_rdy;
  assign s_tready = !in_vld || out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tready) begin
        in_vld <= s_tvalid;
      end
      if (out_rdy) begin
        m_tvalid <= proc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_r.op      <= s_tuser;
      in_r.channel <= s_tdata[2:0];
      in_r.mode    <= s_tdata[4:3];
      in_r.value   <= s_tdata[36:5];
      in_r.pin_in  <= s_tdata[44:37];
    end
    if (proc) begin
      pin_level  <= lvl_out;
      pin_drive  <= drv_out;
      read_mode  <= rd_mode;
      read_value <= rd_value;
    end
  end

  assign m_tdata = {6'b0, read_value, read_mode, pin_drive, pin_level};

  // decode
  assign op     = spwm_pkg::op_t'(in_r.op);
  assign ch_ext = IDX_W'(in_r.channel);
  assign idx    = ch_ext[CH_W-1:0];
  assign ch_ok  = 32'(in_r.channel) < 32'(NUM_CHANNELS);
  assign tick   = proc && (op == spwm_pkg::OP_TICK);
  assign wr     = proc && (op == spwm_pkg::OP_WRITE) && ch_ok;

  // write value preparation
  always_comb begin
    per      = in_r.value[PW-1:0];
    duty     = in_r.value[PW+DW-1:PW];
    prod     = (PW+DW)'(per) * (PW+DW)'(duty);
    per_min  = (32'(per) < 32'(PWM_MIN_PERIOD)) ? PW'(PWM_MIN_PERIOD) : per;
    wr_pwm.on_time = (duty == spwm_pkg::DUTY_FULL) ? per : prod[PW+DW-1:DW];
    wr_pwm.period  = per_min;
    wr_width = (in_r.value >= VW'(SLOT_US - 1)) ? SW_W'(SLOT_US - 1)
                                                 : in_r.value[SW_W-1:0];
  end

  spwm_servo_seq #(
    .NUM_CHANNELS (NUM_CHANNELS),
    .SLOT_US      (SLOT_US)
  ) u_seq (
    .clk   (clk),
    .rst   (rst),
    .tick  (tick),
    .width (width_arr[seq_chan]),
    .chan  (seq_chan),
    .evt   (seq_evt)
  );

  for (genvar i = 0; i < NUM_CHANNELS; i++) begin : g_chan
    spwm_chan #(
      .SW_W (SW_W)
    ) u_chan (
      .clk         (clk),
      .rst         (rst),
      .tick        (tick),
      .wr_en       (wr && (idx == CH_W'(i))),
      .wr_mode     (spwm_pkg::mode_t'(in_r.mode)),
      .wr_level    (in_r.value[0]),
      .wr_width    (wr_width),
      .wr_pwm      (wr_pwm),
      .servo_hit   (seq_evt.fire && (seq_chan == CH_W'(i))),
      .servo_level (seq_evt.level),
      .mode_next   (mode_nx[i]),
      .level_next  (level_nx[i]),
      .width       (width_arr[i])
    );
  end

  for (genvar p = 0; p < NP; p++) begin : g_pin
    if (p < NUM_CHANNELS) begin : g_used
      assign lvl_out[p] = level_nx[p];
      assign drv_out[p] = (mode_nx[p] != spwm_pkg::MODE_IN);
    end else begin : g_unused
      assign lvl_out[p] = 1'b0;
      assign drv_out[p] = 1'b0;
    end
  end

  // read port
  always_comb begin
    rd_mode  = spwm_pkg::MODE_IN;
    rd_value = '0;
    if (op == spwm_pkg::OP_READ && ch_ok) begin
      rd_mode = mode_nx[idx];
      case (mode_nx[idx])
        spwm_pkg::MODE_IN:    rd_value = VW'(in_r.pin_in[in_r.channel]);
        spwm_pkg::MODE_OUT:   rd_value = VW'(level_nx[idx]);
        spwm_pkg::MODE_SERVO: rd_value = VW'(width_arr[idx]);
        default:              rd_value = spwm_pkg::READ_ALL_ONES;
      endcase
    end
  end

endmodule

/* rtl/spwm_servo_seq.sv */
// ----------------------------------------------------------------------------
// spwm_servo_seq
// Servo slot sequencer: walks the channels, high then low phase per slot.
// ----------------------------------------------------------------------------
module spwm_servo_seq #(
  parameter int NUM_CHANNELS = 8,
  parameter int SLOT_US      = 4000,
  localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int SW_W = $clog2(((SLOT_US > spwm_pkg::SERVO_WIDTH_RST) ?
                                SLOT_US : spwm_pkg::SERVO_WIDTH_RST) + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick,
  input  logic [SW_W-1:0]      width,
  output logic [CH_W-1:0]      chan,
  output spwm_pkg::servo_evt_t evt
);

  logic [SW_W-1:0] count, count_next;
  logic            phase, phase_next;
  logic [CH_W-1:0] chan_next;
  logic [SW_W-1:0] len_lo, len;

  always_comb begin
    len_lo     = (width >= SW_W'(SLOT_US)) ? SW_W'(1) : SW_W'(SLOT_US) - width;
    len        = phase ? len_lo : width;
    count_next = count;
    phase_next = phase;
    chan_next  = chan;
    evt        = '0;
    if (tick) begin
      if (count > SW_W'(1)) begin
        count_next = count - SW_W'(1);
      end else begin
        count_next = (len == '0) ? SW_W'(1) : len;
        evt.fire   = 1'b1;
        evt.level  = ~phase;
        phase_next = ~phase;
        if (phase) begin
          chan_next = (chan == CH_W'(NUM_CHANNELS - 1)) ? '0 : chan + CH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= SW_W'(1);
      phase <= 1'b0;
      chan  <= '0;
    end else begin
      count <= count_next;
      phase <= phase_next;
      chan  <= chan_next;
    end
  end

endmodule

/* rtl/spwm_chan.sv */
// ----------------------------------------------------------------------------
// spwm_chan
// One pin channel: mode, servo width, slow PWM counter and output latch.
// ----------------------------------------------------------------------------
module spwm_chan #(
  parameter int SW_W = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                tick,
  input  logic                wr_en,
  input  spwm_pkg::mode_t     wr_mode,
  input  logic                wr_level,
  input  logic [SW_W-1:0]     wr_width,
  input  spwm_pkg::pwm_cfg_t  wr_pwm,
  input  logic                servo_hit,
  input  logic                servo_level,
  output spwm_pkg::mode_t     mode_next,
  output logic                level_next,
  output logic [SW_W-1:0]     width
);

  localparam int PW = spwm_pkg::PWM_W;

  spwm_pkg::mode_t mode;
  logic [SW_W-1:0] width_next;
  logic [PW-1:0]   on_time, on_time_next;
  logic [PW-1:0]   period, period_next;
  logic [PW-1:0]   count, count_next;
  logic            in_high, in_high_next;
  logic            running, running_next;
  logic            level;
  logic [PW-1:0]   off_time;
  logic            high;

  always_comb begin
    off_time     = (period > on_time) ? period - on_time : '0;
    high         = in_high ? (off_time == '0) : (on_time != '0);
    mode_next    = mode;
    level_next   = level;
    width_next   = width;
    on_time_next = on_time;
    period_next  = period;
    count_next   = count;
    in_high_next = in_high;
    running_next = running;
    if (tick) begin
      if (servo_hit && mode == spwm_pkg::MODE_SERVO) begin
        level_next = servo_level;
      end
      if (running) begin
        if (count > PW'(1)) begin
          count_next = count - PW'(1);
        end else begin
          in_high_next = high;
          count_next   = high ? on_time : off_time;
          if (count_next == '0) begin
            count_next = PW'(1);
          end
          if (mode == spwm_pkg::MODE_PWM) begin
            level_next = high;
          end
        end
      end
    end else if (wr_en) begin
      mode_next = wr_mode;
      case (wr_mode)
        spwm_pkg::MODE_OUT: begin
          level_next = wr_level;
        end
        spwm_pkg::MODE_SERVO: begin
          width_next = wr_width;
        end
        spwm_pkg::MODE_PWM: begin
          on_time_next = wr_pwm.on_time;
          period_next  = wr_pwm.period;
          if (!running) begin
            running_next = 1'b1;
            count_next   = '0;
            in_high_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= spwm_pkg::MODE_IN;
      level   <= 1'b0;
      width   <= SW_W'(spwm_pkg::SERVO_WIDTH_RST);
      on_time <= '0;
      period  <= '0;
      count   <= '0;
      in_high <= 1'b0;
      running <= 1'b0;
    end else begin
      mode    <= mode_next;
      level   <= level_next;
      width   <= width_next;
      on_time <= on_time_next;
      period  <= period_next;
      count   <= count_next;
      in_high <= in_high_next;
      running <= running_next;
    end
  end

endmodule

/* rtl/spwm_checker.sv */
// ----------------------------------------------------------------------------
// spwm_checker
// Port-level checks of the pin generator, bound to the top level.
// ----------------------------------------------------------------------------
module spwm_checker #(
  parameter int SLOT_US = 4000
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [47:0] s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  localparam int WIDTH_MAX = (SLOT_US - 1 > spwm_pkg::SERVO_WIDTH_RST) ?
                             SLOT_US - 1 : spwm_pkg::SERVO_WIDTH_RST;

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result word valid straight after reset");

  a_pwm_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17:16] == spwm_pkg::MODE_PWM
      |-> m_tdata[49:18] == spwm_pkg::READ_ALL_ONES)
    else $error("PWM read value not all ones");

  a_servo_read: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17:16] == spwm_pkg::MODE_SERVO
      |-> m_tdata[49:18] <= 32'(WIDTH_MAX))
    else $error("servo width beyond clamp");

  a_read_driven: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17:16] != spwm_pkg::MODE_IN |-> m_tdata[15:8] != 8'd0)
    else $error("driven mode read with no pin driven");

endmodule

bind servo_pwm_pin_generator_top spwm_checker #(.SLOT_US(SLOT_US)) u_spwm_checker (.*);
